FILE: design/assert_macros.svh
// assertion helpers used by the key_value_table top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define KVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Types and constants shared by the key-value table controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;
	localparam int SLOT_BITS  = $clog2(CAPACITY);

	localparam int KEY_FIELD_BITS   = 64;
	localparam int VALUE_FIELD_BITS = 64;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_UPDATE = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EXISTS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		cmd_t                        command;
		logic [KEY_FIELD_BITS-1:0]   key;
		logic [VALUE_FIELD_BITS-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic                        found;
		logic [VALUE_FIELD_BITS-1:0] value_out;
		status_t                     status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_t;

endpackage

FILE: design/kvt_ctrl.sv
// ----------------------------------------------------------------------------
// kvt_ctrl
// Sequencer: captures a request, then runs the lookup and write-back state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output kvt_pkg::ctrl_t ctrl
);
	import kvt_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= ctrl.exec;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctrl      = '0;
		busy      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				busy      = 1'b1;
				ctrl.exec = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

FILE: design/kvt_datapath.sv
// ----------------------------------------------------------------------------
// kvt_datapath
// Slot storage with parallel key match, free-slot pick and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvt_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  kvt_pkg::ctrl_t ctrl,
	input  kvt_pkg::req_t  req,
	output kvt_pkg::rsp_t  rsp
);
	import kvt_pkg::*;

	req_t                  req_q;
	rsp_t                  rsp_q;
	logic [CAPACITY-1:0]   valid_q;
	logic [KEY_BITS-1:0]   key_q [CAPACITY];
	logic [VALUE_BITS-1:0] val_q [CAPACITY];

	logic [KEY_BITS-1:0]   key_c;
	logic [VALUE_BITS-1:0] val_c;
	logic                  hit;
	logic [SLOT_BITS-1:0]  hit_idx;
	logic                  has_free;
	logic [SLOT_BITS-1:0]  free_idx;
	logic [VALUE_BITS-1:0] hit_val;
	logic                  is_write;
	rsp_t                  rsp_c;

	assign key_c    = req_q.key[KEY_BITS-1:0];
	assign val_c    = req_q.value_in[VALUE_BITS-1:0];
	assign is_write = (req_q.command == CMD_INSERT) || (req_q.command == CMD_UPDATE);

	// associative match and lowest free slot, downward scan so the lowest wins
	always_comb begin
		hit      = 1'b0;
		hit_idx  = '0;
		has_free = 1'b0;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == key_c) begin
				hit     = 1'b1;
				hit_idx = SLOT_BITS'(i);
			end
			if (!valid_q[i]) begin
				has_free = 1'b1;
				free_idx = SLOT_BITS'(i);
			end
		end
	end

	assign hit_val = val_q[hit_idx];

	always_comb begin
		rsp_c.found     = hit;
		rsp_c.value_out = '0;
		rsp_c.status    = ST_OK;
		case (req_q.command)
			CMD_INSERT, CMD_UPDATE: begin
				if (hit) begin
					if (req_q.command == CMD_INSERT) begin
						rsp_c.status = ST_EXISTS;
					end
				end else if (!has_free) begin
					rsp_c.status = ST_FULL;
				end
			end
			CMD_DELETE, CMD_FIND: begin
				if (hit) begin
					rsp_c.value_out = VALUE_FIELD_BITS'(hit_val);
				end
			end
			default: begin
				rsp_c.status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			req_q <= req;
		end
		if (ctrl.exec) begin
			rsp_q <= rsp_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctrl.exec) begin
			if (is_write && !hit && has_free) begin
				valid_q[free_idx] <= 1'b1;
			end else if (req_q.command == CMD_DELETE && hit) begin
				valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	// key and value storage
	always_ff @(posedge clk) begin
		if (ctrl.exec && is_write) begin
			if (hit) begin
				if (req_q.command == CMD_UPDATE) begin
					val_q[hit_idx] <= val_c;
				end
			end else if (has_free) begin
				key_q[free_idx] <= key_c;
				val_q[free_idx] <= val_c;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

FILE: design/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table
// Bounded key-value table with associative key match over all slots.
// ----------------------------------------------------------------------------
// Usage:
//   A request (command, key, value_in) is taken on a rising edge where start
//   is high and busy is low. Commands are insert, update-or-insert, delete
//   and find.
//   The cycle after the transfer, busy is high while every slot's key is
//   compared at once and the matched or lowest free slot is written back.
//   The next cycle done is high for exactly one cycle with found, value_out
//   and status; busy is low again then, so a new request may already be
//   taken in that cycle.
//   A new request is not taken while busy is high, during the compare and
//   write-back; done and the result are registered at the end of it.
//   The receiver cannot stall; each result is valid only while done is high.
//   Reset (arst_n low) empties the table at once and returns to idle; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_value_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kvt_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output kvt_pkg::rsp_t rsp
);
	import kvt_pkg::*;

	ctrl_t ctrl;

	kvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	kvt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.req    (req),
		.rsp    (rsp)
	);

	`KVT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done, "transfer must lead to busy")
	`KVT_ASSERT_NEXT(a_busy_done, clk, arst_n, busy, done && !busy, "busy cycle must end with done")
	`KVT_ASSERT_NOW(a_exists_found, clk, arst_n, done && rsp.status == ST_EXISTS, rsp.found && rsp.value_out == '0, "exists without hit")
	`KVT_ASSERT_NOW(a_full_miss, clk, arst_n, done && rsp.status == ST_FULL, !rsp.found && rsp.value_out == '0, "full with hit")

endmodule

FILE: tb/sv/key_value_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_table_test
// Self-checking bench for the key-value table. A shadow copy of the slots
// predicts found, value_out and status for every request transfer; each done
// strobe is checked against the oldest prediction. Directed requests hit the
// empty table, duplicate inserts, full-table rejects and one-bit key misses,
// then about 650 random requests from a small key pool alternate between
// fill, drain and mixed phases with random start gaps.
// ----------------------------------------------------------------------------

class kvt_table_shadow;
	bit slot_used [kvt_pkg::CAPACITY];
	logic [kvt_pkg::KEY_FIELD_BITS-1:0] slot_key [kvt_pkg::CAPACITY];
	logic [kvt_pkg::VALUE_FIELD_BITS-1:0] slot_val [kvt_pkg::CAPACITY];
	kvt_pkg::rsp_t awaited [$];
	int errors;
	int requests;
	int results;
	int hits;
	int fulls;
	int dup_keys;
	int per_cmd [4];

	function new();
		foreach (slot_used[i])
			slot_used[i] = 1'b0;
		foreach (per_cmd[i])
			per_cmd[i] = 0;
		errors = 0;
		requests = 0;
		results = 0;
		hits = 0;
		fulls = 0;
		dup_keys = 0;
	endfunction

	function int outstanding();
		return awaited.size();
	endfunction

	// apply one request to the shadow slots and queue its response
	function void note_request(kvt_pkg::req_t r);
		logic [kvt_pkg::KEY_FIELD_BITS-1:0] kmask;
		logic [kvt_pkg::VALUE_FIELD_BITS-1:0] vmask;
		logic [kvt_pkg::KEY_FIELD_BITS-1:0] k;
		logic [kvt_pkg::VALUE_FIELD_BITS-1:0] v;
		int hit_idx;
		int free_idx;
		kvt_pkg::rsp_t e;
		kmask = '1;
		kmask = kmask >> (kvt_pkg::KEY_FIELD_BITS - kvt_pkg::KEY_BITS);
		vmask = '1;
		vmask = vmask >> (kvt_pkg::VALUE_FIELD_BITS - kvt_pkg::VALUE_BITS);
		k = r.key & kmask;
		v = r.value_in & vmask;
		hit_idx = -1;
		free_idx = -1;
		for (int i = 0; i < kvt_pkg::CAPACITY; i++) begin
			if (slot_used[i] && slot_key[i] == k && hit_idx < 0)
				hit_idx = i;
			if (!slot_used[i] && free_idx < 0)
				free_idx = i;
		end
		e.found = (hit_idx >= 0);
		e.value_out = '0;
		e.status = kvt_pkg::ST_OK;
		case (r.command)
			kvt_pkg::CMD_INSERT, kvt_pkg::CMD_UPDATE: begin
				if (hit_idx >= 0) begin
					if (r.command == kvt_pkg::CMD_INSERT)
						e.status = kvt_pkg::ST_EXISTS;
					else
						slot_val[hit_idx] = v;
				end else if (free_idx >= 0) begin
					slot_used[free_idx] = 1'b1;
					slot_key[free_idx] = k;
					slot_val[free_idx] = v;
				end else begin
					e.status = kvt_pkg::ST_FULL;
				end
			end
			kvt_pkg::CMD_DELETE: begin
				if (hit_idx >= 0) begin
					e.value_out = slot_val[hit_idx] & vmask;
					slot_used[hit_idx] = 1'b0;
				end
			end
			default: begin
				if (hit_idx >= 0)
					e.value_out = slot_val[hit_idx] & vmask;
			end
		endcase
		requests++;
		per_cmd[r.command]++;
		if (e.found)
			hits++;
		if (e.status == kvt_pkg::ST_FULL)
			fulls++;
		if (e.status == kvt_pkg::ST_EXISTS)
			dup_keys++;
		awaited.push_back(e);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	task check_response(kvt_pkg::rsp_t got);
		kvt_pkg::rsp_t want;
		results++;
		if (awaited.size() == 0) begin
			report("response with no request outstanding", 64'(got.value_out), '0);
		end else begin
			want = awaited.pop_front();
			if (got.found !== want.found)
				report("found", 64'(got.found), 64'(want.found));
			if (got.value_out !== want.value_out)
				report("value_out", got.value_out, want.value_out);
			if (got.status !== want.status)
				report("status", 64'(got.status), 64'(want.status));
		end
	endtask

	task close_out();
		while (awaited.size() != 0) begin
			report("response never arrived", '0, '0);
			void'(awaited.pop_front());
		end
	endtask
endclass

module key_value_table_test;
	import kvt_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 650;
	localparam int POOL_SIZE = 24;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	kvt_table_shadow shadow = new();
	logic [63:0] key_pool [POOL_SIZE];
	int cycles = 0;

	key_value_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_response(rsp);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycles, shadow.outstanding());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly pool keys so hits, duplicates and a full table happen often
	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else if (r < 90)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (64'd1 << $urandom_range(0, 63));
		return rand64();
	endfunction

	function automatic logic [63:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		return rand64();
	endfunction

	// phase 0 fills, phase 1 drains, phase 2 is an even mix
	function automatic cmd_t pick_command(int phase);
		int r;
		r = $urandom_range(0, 99);
		case (phase)
			0: return (r < 40) ? CMD_INSERT : (r < 80) ? CMD_UPDATE :
				(r < 90) ? CMD_FIND : CMD_DELETE;
			1: return (r < 50) ? CMD_DELETE : (r < 75) ? CMD_FIND :
				(r < 90) ? CMD_INSERT : CMD_UPDATE;
			default: return cmd_t'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic send(cmd_t c, logic [63:0] k, logic [63:0] v);
		@(negedge clk);
		start <= 1'b1;
		req <= '{command: c, key: k, value_in: v};
		do @(posedge clk); while (busy);
		shadow.note_request(req);
	endtask

	task automatic idle(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
			req <= '{command: cmd_t'($urandom_range(0, 3)), key: rand64(), value_in: rand64()};
		end
	endtask

	task automatic random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return;
		else if (r < 90)
			idle($urandom_range(1, 3));
		else
			idle($urandom_range(8, 30));
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	// insert, look up, overwrite, look up, remove
	task automatic key_lifecycle();
		logic [63:0] k;
		k = pick_key();
		send(CMD_INSERT, k, pick_value());
		random_gap();
		send(CMD_FIND, k, pick_value());
		send(CMD_UPDATE, k, pick_value());
		random_gap();
		send(CMD_FIND, k, pick_value());
		send(CMD_DELETE, k, pick_value());
	endtask

	initial begin
		int phase;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'h5555_5555_5555_5555;
		key_pool[3] = 64'haaaa_aaaa_aaaa_aaaa;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = rand64();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, duplicate insert, overwrite, one-bit key miss
		send(CMD_FIND, key_pool[0], '1);
		send(CMD_DELETE, key_pool[1], '1);
		send(CMD_INSERT, key_pool[0], '1);
		send(CMD_INSERT, key_pool[0], 64'h1234);
		send(CMD_UPDATE, key_pool[0], '0);
		send(CMD_FIND, key_pool[0], '1);
		send(CMD_FIND, 64'h1, '0);
		send(CMD_UPDATE, key_pool[1], key_pool[2]);
		// fill every slot, then push past capacity
		for (int i = 0; i < CAPACITY - 2; i++)
			send(CMD_INSERT, key_pool[2 + i], key_pool[3 - (i % 2)]);
		send(CMD_INSERT, key_pool[CAPACITY + 2], '1);
		send(CMD_UPDATE, key_pool[CAPACITY + 3], '1);
		send(CMD_UPDATE, key_pool[4], '1);
		send(CMD_DELETE, key_pool[0], '1);
		send(CMD_FIND, key_pool[0], '0);
		send(CMD_INSERT, key_pool[CAPACITY + 2], 64'h8000_0000_0000_0001);
		wait_quiet();

		phase = 2;
		while (shadow.requests < RANDOM_ITEMS + 28) begin
			if ($urandom_range(0, 49) == 0)
				phase = $urandom_range(0, 2);
			if ($urandom_range(0, 149) == 0)
				wait_quiet();
			if ($urandom_range(0, 9) == 0)
				key_lifecycle();
			else
				send(pick_command(phase), pick_key(), pick_value());
			random_gap();
		end

		wait_quiet();
		repeat (4) @(posedge clk);
		shadow.close_out();
		$display("%0d requests (%0d insert, %0d update, %0d delete, %0d find), %0d responses",
			shadow.requests, shadow.per_cmd[CMD_INSERT], shadow.per_cmd[CMD_UPDATE],
			shadow.per_cmd[CMD_DELETE], shadow.per_cmd[CMD_FIND], shadow.results);
		$display("key hits %0d, table full %0d, duplicate inserts %0d, mismatches %0d",
			shadow.hits, shadow.fulls, shadow.dup_keys, shadow.errors);
		if (shadow.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/kvt_pkg.sv
design/kvt_ctrl.sv
design/kvt_datapath.sv
design/key_value_table.sv
tb/sv/key_value_table_test.sv
